### hw/rtl/sacf_pkg.sv
`default_nettype none
package sacf_pkg;

	localparam int ADDR_W = 12;
	localparam logic [7:0] MEM_INIT = 8'h26;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        was_hit;
		logic [1:0]  way_used;
		logic [31:0] access_count;
		logic [31:0] miss_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL,
		ST_DRAIN,
		ST_ACCESS,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic clear_wr;
		logic flush;
		logic lookup;
		logic fill_rd;
		logic access;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic is_access;
		logic hit;
		logic clear_last;
		logic fill_last;
	} status_t;

endpackage
`default_nettype wire

### hw/rtl/sacf_ctrl.sv
`default_nettype none
module sacf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sacf_pkg::status_t status,
	output sacf_pkg::cmd_t         cmd,
	output logic                   busy
);

	sacf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacf_pkg::ST_CLEAR: begin
				if (status.clear_last) state_d = sacf_pkg::ST_IDLE;
			end
			sacf_pkg::ST_IDLE: begin
				if (start) state_d = sacf_pkg::ST_LOOKUP;
			end
			sacf_pkg::ST_LOOKUP: begin
				if (!status.is_access) state_d = sacf_pkg::ST_RESP;
				else if (status.hit) state_d = sacf_pkg::ST_ACCESS;
				else state_d = sacf_pkg::ST_FILL;
			end
			sacf_pkg::ST_FILL: begin
				if (status.fill_last) state_d = sacf_pkg::ST_DRAIN;
			end
			sacf_pkg::ST_DRAIN:  state_d = sacf_pkg::ST_ACCESS;
			sacf_pkg::ST_ACCESS: state_d = sacf_pkg::ST_RESP;
			sacf_pkg::ST_RESP:   state_d = sacf_pkg::ST_IDLE;
			default:             state_d = sacf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			sacf_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
			sacf_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			sacf_pkg::ST_LOOKUP: begin
				cmd.flush  = status.is_flush;
				cmd.lookup = status.is_access;
			end
			sacf_pkg::ST_FILL:   cmd.fill_rd = 1'b1;
			sacf_pkg::ST_DRAIN:  cmd = '0;
			sacf_pkg::ST_ACCESS: cmd.access = 1'b1;
			sacf_pkg::ST_RESP:   cmd.respond = 1'b1;
			default:             cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/sacf_dp.sv
`default_nettype none
module sacf_dp #(
	parameter int WAYS       = 4,
	parameter int SETS       = 8,
	parameter int LINE_BYTES = 64,
	parameter int MEM_BYTES  = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sacf_pkg::req_t req,
	input  wire sacf_pkg::cmd_t cmd,
	output sacf_pkg::status_t   status,
	output sacf_pkg::rsp_t      result
);

	localparam int WAY_W = $clog2(WAYS);
	localparam int SET_W = $clog2(SETS);
	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int MA_W  = $clog2(MEM_BYTES);
	localparam int TAG_RAW = MA_W - OFF_W - SET_W;
	localparam int TAG_W = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int CNT_W = (MA_W > OFF_W) ? MA_W : OFF_W;
	localparam int LD_W  = WAY_W + SET_W + OFF_W;
	localparam int LD_DEPTH = WAYS * SETS * LINE_BYTES;

	sacf_pkg::req_t req_q;
	logic [WAYS-1:0][SETS-1:0]             valid_q;
	logic [WAYS-1:0][SETS-1:0][TAG_W-1:0]  tag_q;
	logic [SETS-1:0][WAYS-1:0][WAY_W-1:0]  fifo_q;
	logic [31:0]      acc_q, miss_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit_q;
	logic [WAY_W-1:0] way_q;
	logic [7:0]       rd_q, mem_rd_q;
	logic             fill_wr_s1;
	logic [OFF_W-1:0] fill_idx_s1;

	logic [7:0] mem [0:MEM_BYTES-1];
	logic [7:0] line_mem [0:LD_DEPTH-1];

	logic [MA_W-1:0]  maddr;
	logic [SET_W-1:0] set_idx;
	logic [OFF_W-1:0] off_idx;
	logic [TAG_W-1:0] tag;
	logic [WAYS-1:0]  match;
	logic             hit;
	logic [WAY_W-1:0] hit_way, oldest;
	logic             is_write;

	assign maddr   = MA_W'(req_q.address);
	assign off_idx = maddr[OFF_W-1:0];
	assign set_idx = maddr[OFF_W +: SET_W];
	assign tag     = TAG_W'(maddr >> (OFF_W + SET_W));
	assign oldest  = fifo_q[set_idx][0];
	assign is_write = (req_q.req_type == sacf_pkg::REQ_WRITE);

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid_q[w][set_idx] && (tag_q[w][set_idx] == tag);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	assign status.is_flush   = (req_q.req_type == sacf_pkg::REQ_FLUSH);
	assign status.is_access  = (req_q.req_type == sacf_pkg::REQ_READ) || is_write;
	assign status.hit        = hit;
	assign status.clear_last = (cnt_q == CNT_W'(MEM_BYTES - 1));
	assign status.fill_last  = (cnt_q == CNT_W'(LINE_BYTES - 1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			acc_q      <= '0;
			miss_q     <= '0;
			cnt_q      <= '0;
			fill_wr_s1 <= 1'b0;
			for (int s = 0; s < SETS; s++) begin
				for (int w = 0; w < WAYS; w++) begin
					fifo_q[s][w] <= WAY_W'(w);
				end
			end
		end else begin
			fill_wr_s1 <= cmd.fill_rd;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.clear_wr || cmd.fill_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.flush) begin
				valid_q <= '0;
				for (int s = 0; s < SETS; s++) begin
					for (int w = 0; w < WAYS; w++) begin
						fifo_q[s][w] <= WAY_W'(w);
					end
				end
			end
			if (cmd.lookup) begin
				if (acc_q != '1) acc_q <= acc_q + 1'b1;
				if (!hit) begin
					if (miss_q != '1) miss_q <= miss_q + 1'b1;
					valid_q[oldest][set_idx] <= 1'b1;
					for (int w = 0; w + 1 < WAYS; w++) begin
						fifo_q[set_idx][w] <= fifo_q[set_idx][w + 1];
					end
					fifo_q[set_idx][WAYS - 1] <= oldest;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		fill_idx_s1 <= cnt_q[OFF_W-1:0];
		if (cmd.load) begin
			req_q <= req;
			hit_q <= 1'b0;
			way_q <= '0;
		end
		if (cmd.lookup) begin
			hit_q <= hit;
			way_q <= hit ? hit_way : oldest;
			if (!hit) tag_q[oldest][set_idx] <= tag;
		end
	end

	// backing memory
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			mem[cnt_q[MA_W-1:0]] <= sacf_pkg::MEM_INIT;
		end else if (cmd.access && is_write) begin
			mem[maddr] <= req_q.write_data;
		end
		mem_rd_q <= mem[{maddr[MA_W-1:OFF_W], cnt_q[OFF_W-1:0]}];
	end

	// line storage
	always_ff @(posedge clk) begin
		if (fill_wr_s1) begin
			line_mem[LD_W'({way_q, set_idx, fill_idx_s1})] <= mem_rd_q;
		end else if (cmd.access && is_write) begin
			line_mem[LD_W'({way_q, set_idx, off_idx})] <= req_q.write_data;
		end
		rd_q <= line_mem[LD_W'({way_q, set_idx, off_idx})];
	end

	assign result.read_data    = (req_q.req_type == sacf_pkg::REQ_READ) ? rd_q : 8'd0;
	assign result.was_hit      = hit_q;
	assign result.way_used     = 2'(way_q);
	assign result.access_count = acc_q;
	assign result.miss_count   = miss_q;

endmodule
`default_nettype wire

### hw/rtl/set_assoc_cache_fifo_wt_wa_top.sv
`default_nettype none
// Steps: hit: lookup, access, response; miss: lookup, refill, drain, access, response;
// flush, unused: lookup, response. The refill (one backing byte per cycle) sets miss time.
// Throughput: one transaction at a time; busy stays high until done has pulsed.
// Reset: arst_n clears control state, then a clear pass loads every
// backing byte with 0x26 while busy is high.
// Results pulse done for one cycle; the receiver cannot stall.
module set_assoc_cache_fifo_wt_wa_top #(
	parameter int WAYS       = 4,
	parameter int SETS       = 8,
	parameter int LINE_BYTES = 64,
	parameter int MEM_BYTES  = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire sacf_pkg::req_t req,
	output logic                busy,
	output logic                done,
	output sacf_pkg::rsp_t      result
);

	sacf_pkg::cmd_t    cmd;
	sacf_pkg::status_t status;

	// sequence the lookup, refill and access steps
	sacf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold tags, order, line bytes, backing memory and counters
	sacf_dp #(
		.WAYS       (WAYS),
		.SETS       (SETS),
		.LINE_BYTES (LINE_BYTES),
		.MEM_BYTES  (MEM_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	// pulse the result for the one cycle of the response step
	assign done = cmd.respond;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after a transaction completed");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	a_miss_le_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.miss_count <= result.access_count))
		else $error("miss count exceeds access count");

endmodule
`default_nettype wire
